/* hw/rtl/assert_macros.svh */
// Concurrent assertion helpers, sampled on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/rrefc_pkg.sv */
package rrefc_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 32;
  localparam int FRAC_BITS = 16;

  localparam int ENTRY_W   = 32;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_CFG_W = 7;
  localparam int COL_CFG_W = 6;
  localparam int PIVOT_W   = COL_W + 1;
  localparam int VERDICT_W = 1 + 3 + ROW_W + COL_W;
  localparam int OUT_TDATA_W = ((VERDICT_W + 7) / 8) * 8;

  localparam logic [ENTRY_W-1:0] ENTRY_ONE  = ENTRY_W'(1) << FRAC_BITS;
  localparam logic [PIVOT_W-1:0] PIVOT_NONE = '1;

  typedef enum logic [2:0] {
    REASON_NONE       = 3'd0,
    REASON_NOT_ONE    = 3'd1,
    REASON_NOT_RIGHT  = 3'd2,
    REASON_PIVOT_COL  = 3'd3,
    REASON_AFTER_ZERO = 3'd4
  } rrefc_reason_t;

  typedef struct packed {
    logic [COL_W-1:0]    col_index;
    logic [ROW_W-1:0]    row_index;
    logic                pivot_found_in_row;
    logic [PIVOT_W-1:0]  last_pivot_col;
    logic [MAX_COLS-1:0] column_nonzero_mask;
    logic                zero_row_seen;
    logic                failure_latched;
    rrefc_reason_t       latched_reason;
    logic [ROW_W-1:0]    latched_row;
    logic [COL_W-1:0]    latched_col;
  } rrefc_state_t;

  typedef struct packed {
    logic             is_rref;
    rrefc_reason_t    fail_reason;
    logic [ROW_W-1:0] fail_row;
    logic [COL_W-1:0] fail_col;
  } rrefc_verdict_t;

  localparam rrefc_state_t STATE_RESET = '{
    col_index:           '0,
    row_index:           '0,
    pivot_found_in_row:  1'b0,
    last_pivot_col:      PIVOT_NONE,
    column_nonzero_mask: '0,
    zero_row_seen:       1'b0,
    failure_latched:     1'b0,
    latched_reason:      REASON_NONE,
    latched_row:         '0,
    latched_col:         '0
  };

endpackage

/* hw/rtl/rrefc_step.sv */
module rrefc_step (
  input  rrefc_pkg::rrefc_state_t                 st,
  input  logic [rrefc_pkg::ENTRY_W-1:0]           entry,
  input  logic [rrefc_pkg::ROW_CFG_W-1:0]         rows,
  input  logic [rrefc_pkg::COL_CFG_W-1:0]         cols,
  output rrefc_pkg::rrefc_state_t                 st_next,
  output logic                                    emit,
  output rrefc_pkg::rrefc_verdict_t               verdict
);
  import rrefc_pkg::*;

  logic          nonzero;
  logic          fire;
  rrefc_reason_t fire_reason;
  logic          last_col;
  logic          last_row;
  rrefc_state_t  upd;

  always_comb begin
    nonzero     = (entry != '0);
    fire        = 1'b0;
    fire_reason = REASON_NONE;
    upd         = st;

    if (nonzero) begin
      if (st.zero_row_seen) begin
        fire        = 1'b1;
        fire_reason = REASON_AFTER_ZERO;
      end else if (!st.pivot_found_in_row) begin
        if (entry != ENTRY_ONE) begin
          fire        = 1'b1;
          fire_reason = REASON_NOT_ONE;
        end else if (st.last_pivot_col != PIVOT_NONE &&
                     {1'b0, st.col_index} <= st.last_pivot_col) begin
          fire        = 1'b1;
          fire_reason = REASON_NOT_RIGHT;
        end else if (st.column_nonzero_mask[st.col_index]) begin
          fire        = 1'b1;
          fire_reason = REASON_PIVOT_COL;
        end
        upd.pivot_found_in_row = 1'b1;
        upd.last_pivot_col     = {1'b0, st.col_index};
      end
      upd.column_nonzero_mask[st.col_index] = 1'b1;
    end

    // keep only the first failure of the matrix
    if (fire && !st.failure_latched) begin
      upd.failure_latched = 1'b1;
      upd.latched_reason  = fire_reason;
      upd.latched_row     = st.row_index;
      upd.latched_col     = st.col_index;
    end

    last_col = (COL_CFG_W'({1'b0, st.col_index}) + COL_CFG_W'(1)) >= cols;
    last_row = (ROW_CFG_W'({1'b0, st.row_index}) + ROW_CFG_W'(1)) >= rows;

    verdict.is_rref     = !upd.failure_latched;
    verdict.fail_reason = upd.latched_reason;
    verdict.fail_row    = upd.latched_row;
    verdict.fail_col    = upd.latched_col;

    emit    = 1'b0;
    st_next = upd;
    if (!last_col) begin
      st_next.col_index = st.col_index + COL_W'(1);
    end else begin
      if (!upd.pivot_found_in_row) begin
        st_next.zero_row_seen = 1'b1;
      end
      st_next.pivot_found_in_row = 1'b0;
      st_next.col_index          = '0;
      if (!last_row) begin
        st_next.row_index = st.row_index + ROW_W'(1);
      end else begin
        emit    = 1'b1;
        st_next = STATE_RESET;
      end
    end
  end

endmodule

/* hw/rtl/rref_checker.sv */
// Reduced row echelon form checker. Matrix entries stream in on s_tdata in
// row-major order as signed Q16.16 values, one transfer per entry and one
// entry per cycle sustained. After the last entry of a row_count by
// col_count matrix one verdict transfer leaves on m_tdata: the pass flag,
// the reason code of the first failure met in row-major order, and that
// failure's row and column. The verdict is registered: the last entry sits
// in the input register while the check logic feeds the result register.
// Input is stalled only when a finished verdict still waits on m_tready and
// the held entry would produce the next one. Dimensions must be written over
// the register port at byte addresses 0 (rows) and 4 (columns) between
// matrices; the block itself does not enforce this. The low 7 row and 6
// column bits are kept; 0 counts as 1 and values past 64 rows or 32 columns
// count as the maximum. Every check state returns to reset after a verdict.
`include "assert_macros.svh"

module rref_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  // entry stream
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [rrefc_pkg::ENTRY_W-1:0]         s_tdata,   // [31:0] entry_value
  // verdict stream
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // [0] is_rref, [3:1] fail_reason, [9:4] fail_row, [14:10] fail_col, [15] zero
  output logic [rrefc_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // register port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [2:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);
  import rrefc_pkg::*;

  logic [ROW_CFG_W-1:0] row_count;
  logic [COL_CFG_W-1:0] col_count;
  logic [ROW_CFG_W-1:0] rows;
  logic [COL_CFG_W-1:0] cols;

  logic                 s1_valid;
  logic [ENTRY_W-1:0]   s1_entry;
  logic                 s1_fire;

  rrefc_state_t         st;
  rrefc_state_t         st_next;
  logic                 step_emit;
  rrefc_verdict_t       step_verdict;
  rrefc_verdict_t       verdict;

  // register port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'(col_count) : 32'(row_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= ROW_CFG_W'(1);
      col_count <= COL_CFG_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        col_count <= pwdata[COL_CFG_W-1:0];
      end else begin
        row_count <= pwdata[ROW_CFG_W-1:0];
      end
    end
  end

  always_comb begin
    if (row_count == '0) begin
      rows = ROW_CFG_W'(1);
    end else if (row_count > ROW_CFG_W'(MAX_ROWS)) begin
      rows = ROW_CFG_W'(MAX_ROWS);
    end else begin
      rows = row_count;
    end
    if (col_count == '0) begin
      cols = COL_CFG_W'(1);
    end else if (col_count > COL_CFG_W'(MAX_COLS)) begin
      cols = COL_CFG_W'(MAX_COLS);
    end else begin
      cols = col_count;
    end
  end

  // hold the entry only if it would finish a matrix into a full result slot
  assign s1_fire  = s1_valid && (!step_emit || !m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_entry <= s_tdata;
    end
  end

  rrefc_step u_step (
    .st      (st),
    .entry   (s1_entry),
    .rows    (rows),
    .cols    (cols),
    .st_next (st_next),
    .emit    (step_emit),
    .verdict (step_verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (s1_fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_fire && step_emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && step_emit) begin
      verdict <= step_verdict;
    end
  end

  assign m_tdata = OUT_TDATA_W'({verdict.fail_col, verdict.fail_row,
                                 verdict.fail_reason, verdict.is_rref});

  `ASSERT_CLK(a_no_overwrite, (s1_valid && step_emit && m_tvalid && !m_tready) |=> s1_valid, "finishing entry advanced over a stalled verdict")
  `ASSERT_CLK(a_clear_after_emit, (s1_fire && step_emit) |=> (st.row_index == '0 && st.col_index == '0 && !st.failure_latched), "matrix state not cleared after verdict")
  `ASSERT_CLK(a_pass_no_reason, m_tvalid |-> (verdict.is_rref == (verdict.fail_reason == REASON_NONE)), "pass flag disagrees with reason code")
  `ASSERT_ALWAYS(a_pivot_col_known, st.pivot_found_in_row |-> (st.last_pivot_col != PIVOT_NONE), "leading one recorded without its column")

endmodule

/* tb/rref_checker_tb.sv */
`timescale 1ns / 100ps

module rref_checker_tb;
  import rrefc_pkg::*;

  localparam logic [2:0]  REG_ROWS = 3'd0;
  localparam logic [2:0]  REG_COLS = 3'd4;
  localparam logic [31:0] ZERO = 32'h0;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_DIRECTED = 12;

  typedef struct packed {
    logic [6:0]        rows;
    logic [5:0]        cols;
    logic [0:5][31:0]  vals;
    logic              known;
    logic              pass;
    rrefc_reason_t     why;
    logic [ROW_W-1:0]  frow;
    logic [COL_W-1:0]  fcol;
  } dir_case_t;

  // Small matrices whose verdict is plain by inspection; one left to the predictor.
  localparam dir_case_t DIRECTED [NUM_DIRECTED] = '{
    '{7'd1, 6'd1, {ENTRY_ONE, ZERO, ZERO, ZERO, ZERO, ZERO},
      1'b1, 1'b1, REASON_NONE, 6'd0, 5'd0},
    '{7'd1, 6'd1, {32'h8000_0000, ZERO, ZERO, ZERO, ZERO, ZERO},
      1'b1, 1'b0, REASON_NOT_ONE, 6'd0, 5'd0},
    '{7'd1, 6'd1, {32'h7FFF_FFFF, ZERO, ZERO, ZERO, ZERO, ZERO},
      1'b1, 1'b0, REASON_NOT_ONE, 6'd0, 5'd0},
    '{7'd1, 6'd1, {32'h0001_0001, ZERO, ZERO, ZERO, ZERO, ZERO},
      1'b1, 1'b0, REASON_NOT_ONE, 6'd0, 5'd0},
    '{7'd2, 6'd2, {ENTRY_ONE, ZERO, ZERO, ENTRY_ONE, ZERO, ZERO},
      1'b0, 1'b1, REASON_NONE, 6'd0, 5'd0},
    '{7'd2, 6'd2, {ZERO, ENTRY_ONE, ENTRY_ONE, ZERO, ZERO, ZERO},
      1'b1, 1'b0, REASON_NOT_RIGHT, 6'd1, 5'd0},
    '{7'd2, 6'd2, {ENTRY_ONE, 32'd5, ZERO, ENTRY_ONE, ZERO, ZERO},
      1'b1, 1'b0, REASON_PIVOT_COL, 6'd1, 5'd1},
    '{7'd2, 6'd2, {ZERO, ZERO, ZERO, ENTRY_ONE, ZERO, ZERO},
      1'b1, 1'b0, REASON_AFTER_ZERO, 6'd1, 5'd1},
    // nonzero directly below a leading one
    '{7'd2, 6'd2, {ENTRY_ONE, ZERO, ENTRY_ONE, ZERO, ZERO, ZERO},
      1'b1, 1'b0, REASON_NOT_RIGHT, 6'd1, 5'd0},
    // only the first failure is reported
    '{7'd2, 6'd2, {32'hFFFF_0000, ZERO, ENTRY_ONE, ZERO, ZERO, ZERO},
      1'b1, 1'b0, REASON_NOT_ONE, 6'd0, 5'd0},
    // after a zero row the zero-row failure wins over a bad leading value
    '{7'd2, 6'd2, {ZERO, ZERO, 32'h0002_0000, ZERO, ZERO, ZERO},
      1'b1, 1'b0, REASON_AFTER_ZERO, 6'd1, 5'd0},
    '{7'd2, 6'd3, {ENTRY_ONE, 32'hFFFF_FFFF, ZERO, ZERO, ZERO, ENTRY_ONE},
      1'b1, 1'b1, REASON_NONE, 6'd0, 5'd0}
  };

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [ENTRY_W-1:0]     s_tdata;      // [31:0] entry_value
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;      // [0] is_rref, [3:1] fail_reason, [9:4] fail_row,
                                        // [14:10] fail_col, [15] zero
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [2:0]             paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  rref_checker DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predictor state
  logic [6:0]     cfg_rows;
  logic [5:0]     cfg_cols;
  int             at_col;
  int             at_row;
  bit             row_has_pivot;
  int             prev_pivot;       // -1 while no leading one yet
  logic [31:0]    col_seen;
  bit             saw_zero_row;
  bit             fail_held;
  rrefc_reason_t  fail_why;
  int             fail_r;
  int             fail_c;

  rrefc_verdict_t verdict_q [$];
  bit             typed_on;
  rrefc_verdict_t typed_verdict;

  int             send_idle_pct;
  int             recv_stall_pct;
  int             hold_left;
  int             mismatches;
  int             entries_sent;
  int             verdicts_seen;
  int             passes_seen;
  int             configs_used;

  logic [31:0]    grid [MAX_ROWS][MAX_COLS];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int clamp_dim(int v, int hi);
    return (v == 0) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic void clear_matrix();
    at_col = 0;
    at_row = 0;
    row_has_pivot = 1'b0;
    prev_pivot = -1;
    col_seen = '0;
    saw_zero_row = 1'b0;
    fail_held = 1'b0;
    fail_why = REASON_NONE;
    fail_r = 0;
    fail_c = 0;
  endfunction

  function automatic void note_failure(rrefc_reason_t why);
    if (!fail_held) begin
      fail_held = 1'b1;
      fail_why = why;
      fail_r = at_row;
      fail_c = at_col;
    end
  endfunction

  // Advance the checker state by one entry; queue the verdict at the matrix end.
  function automatic void check_entry(logic [31:0] raw);
    int rows_eff;
    int cols_eff;
    rrefc_verdict_t v;
    rows_eff = clamp_dim(int'(cfg_rows), MAX_ROWS);
    cols_eff = clamp_dim(int'(cfg_cols), MAX_COLS);
    if (raw != '0) begin
      if (saw_zero_row) note_failure(REASON_AFTER_ZERO);
      else if (!row_has_pivot) begin
        if (raw != ENTRY_ONE) note_failure(REASON_NOT_ONE);
        else if (prev_pivot >= 0 && at_col <= prev_pivot) note_failure(REASON_NOT_RIGHT);
        else if (col_seen[at_col]) note_failure(REASON_PIVOT_COL);
        row_has_pivot = 1'b1;
        prev_pivot = at_col;
      end
      col_seen[at_col] = 1'b1;
    end
    if (at_col + 1 < cols_eff) begin
      at_col++;
      return;
    end
    if (!row_has_pivot) saw_zero_row = 1'b1;
    row_has_pivot = 1'b0;
    at_col = 0;
    if (at_row + 1 < rows_eff) begin
      at_row++;
      return;
    end
    v.is_rref = !fail_held;
    v.fail_reason = fail_why;
    v.fail_row = fail_r[ROW_W-1:0];
    v.fail_col = fail_c[COL_W-1:0];
    verdict_q = {verdict_q, (typed_on ? typed_verdict : v)};
    clear_matrix();
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2: return ZERO;
      3, 4:    return ENTRY_ONE;
      5:       return -ENTRY_ONE;
      6:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      7:       return ENTRY_ONE ^ (32'h1 << $urandom_range(31));
      default: return $urandom();
    endcase
  endfunction

  // Well-formed matrices with random free entries; half of them get a damaged
  // entry or two, about a third stay whole and the rest are replaced by noise.
  task automatic build_matrix();
    int rows_eff;
    int cols_eff;
    int npiv;
    int last;
    int kind;
    bit piv_col [MAX_COLS];
    int pivot_at [MAX_ROWS];
    rows_eff = clamp_dim(int'(cfg_rows), MAX_ROWS);
    cols_eff = clamp_dim(int'(cfg_cols), MAX_COLS);
    for (int r = 0; r < rows_eff; r++)
      for (int c = 0; c < cols_eff; c++) grid[r][c] = ZERO;
    for (int c = 0; c < MAX_COLS; c++) piv_col[c] = 1'b0;
    npiv = $urandom_range((rows_eff < cols_eff) ? rows_eff : cols_eff);
    last = -1;
    for (int r = 0; r < npiv; r++) begin
      pivot_at[r] = $urandom_range(cols_eff - npiv + r, last + 1);
      last = pivot_at[r];
      piv_col[last] = 1'b1;
      grid[r][last] = ENTRY_ONE;
    end
    for (int r = 0; r < npiv; r++)
      for (int c = pivot_at[r] + 1; c < cols_eff; c++)
        if (!piv_col[c]) grid[r][c] = pick_value();
    kind = $urandom_range(99);
    if (kind >= 85) begin
      for (int r = 0; r < rows_eff; r++)
        for (int c = 0; c < cols_eff; c++) grid[r][c] = pick_value();
    end else if (kind >= 35) begin
      repeat ($urandom_range(2, 1))
        grid[$urandom_range(rows_eff - 1)][$urandom_range(cols_eff - 1)] = pick_value();
    end
  endtask

  task automatic push_entry(input logic [31:0] value);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    check_entry(value);
    entries_sent++;
    @(negedge clk);
  endtask

  // Drop valid, drain the verdicts, then cover the pipeline depth.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] stored;
    stored = (addr == REG_ROWS) ? {25'd0, value[6:0]} : {26'd0, value[5:0]};
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == REG_ROWS) cfg_rows = value[6:0];
    else cfg_cols = value[5:0];
    // read back with psel held
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field((addr == REG_ROWS) ? "row_count" : "col_count", stored, prdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input int rows_raw, input int cols_raw, input int s_pct,
                           input int r_pct, input int budget, input int hold);
    int start;
    int rows_eff;
    int cols_eff;
    settle();
    write_reg(REG_ROWS, rows_raw);
    write_reg(REG_COLS, cols_raw);
    configs_used++;
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    hold_left = hold;
    rows_eff = clamp_dim(int'(cfg_rows), MAX_ROWS);
    cols_eff = clamp_dim(int'(cfg_cols), MAX_COLS);
    start = entries_sent;
    while (entries_sent - start < budget) begin
      build_matrix();
      for (int r = 0; r < rows_eff; r++)
        for (int c = 0; c < cols_eff; c++) push_entry(grid[r][c]);
    end
  endtask

  // Receiver: random stalls plus an optional long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : verdict_monitor
    rrefc_verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      verdicts_seen++;
      if (m_tdata[0]) passes_seen++;
      if (verdict_q.size() == 0) begin
        $error("unexpected verdict transfer: tdata %h", m_tdata);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        check_field("is_rref", 32'(want.is_rref), 32'(m_tdata[0]));
        check_field("fail_reason", 32'(want.fail_reason), 32'(m_tdata[3:1]));
        check_field("fail_row", 32'(want.fail_row), 32'(m_tdata[9:4]));
        check_field("fail_col", 32'(want.fail_col), 32'(m_tdata[14:10]));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no transfer for %0d cycles, %0d verdicts outstanding",
             WATCHDOG_LIMIT, verdict_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    dir_case_t dc;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    mismatches = 0;
    entries_sent = 0;
    verdicts_seen = 0;
    passes_seen = 0;
    configs_used = 1;
    typed_on = 1'b0;
    typed_verdict = '0;
    cfg_rows = 7'd1;
    cfg_cols = 6'd1;
    clear_matrix();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      dc = DIRECTED[i];
      if (dc.rows != cfg_rows || dc.cols != cfg_cols) begin
        settle();
        write_reg(REG_ROWS, 32'(dc.rows));
        write_reg(REG_COLS, 32'(dc.cols));
        configs_used++;
      end
      typed_on = dc.known;
      typed_verdict.is_rref = dc.pass;
      typed_verdict.fail_reason = dc.why;
      typed_verdict.fail_row = dc.frow;
      typed_verdict.fail_col = dc.fcol;
      for (int k = 0; k < dc.rows * dc.cols; k++) push_entry(dc.vals[k]);
    end
    settle();
    typed_on = 1'b0;

    run_phase(4, 4, 0, 0, 200, 0);
    // long receiver hold-off with 1x1 matrices so the input backs up
    run_phase(1, 1, 0, 0, 80, 300);
    run_phase(0, 63, 62, 0, 160, 0);
    run_phase(127, 0, 0, 62, 192, 0);
    run_phase(64, 3, 15, 15, 192, 0);
    run_phase(1, 32, 0, 0, 96, 0);
    run_phase($urandom_range(6, 1), $urandom_range(6, 1), 0, 0, 150, 0);
    run_phase($urandom_range(6, 1), $urandom_range(6, 1), 62, 0, 150, 0);
    run_phase($urandom_range(6, 1), $urandom_range(6, 1), 0, 62, 150, 0);
    run_phase($urandom_range(6, 1), $urandom_range(6, 1), 15, 15, 150, 0);
    settle();

    $display("Checked %0d entries over %0d dimension settings, clamped sizes included.",
             entries_sent, configs_used);
    $display("Verdicts compared: %0d, of which %0d passing.", verdicts_seen, passes_seen);
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/rrefc_pkg.sv
hw/rtl/rrefc_step.sv
hw/rtl/rref_checker.sv
tb/rref_checker_tb.sv
